/* rtl/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// bdlp_pkg: shared constants and types of the button debouncer
// Register map codes, register widths and reset values used by the core.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  // Width of the long-press reload register as seen on the register port.
  localparam int unsigned TicksRegWidth = 16;

  // Reset value of the long-press reload register and of the hold counter.
  localparam logic [31:0] LongTicksReset = 32'd300;

  // Width of the register port data bus.
  localparam int unsigned RegDataWidth = 32;

  // Width of the register port address bus (two word registers).
  localparam int unsigned RegAddrWidth = 3;

  // Register index, taken from the word address.
  typedef enum logic {
    REG_LONG_TICKS    = 1'b0,
    REG_PRESSED_LEVEL = 1'b1
  } cfg_reg_e;

endpackage : bdlp_pkg

/* rtl/button_debounce_long_press_core.sv */
// ----------------------------------------------------------------------------
// button_debounce_long_press_core: three-sample debouncer with long press
// Each input transaction carries one sample tick of the raw button levels,
// together with acknowledge masks for the sticky press and long-press flags.
// A button's level is accepted once three successive samples agree; a stable
// change to the pressed level sets its press flag and reloads a hold counter
// that is shared by all buttons, and every stable held button decrements that
// counter in button index order, raising its long-press flag when it reaches
// zero. Every tick produces exactly one result transaction holding the flags
// and accepted levels after the update. An item passes one input register
// and one update into the state registers, and a new item is taken every
// cycle while the result side does not stall; the update of the shared hold
// counter is chained through the buttons and sets the throughput. The two
// registers sit at byte addresses 0 (long-press ticks) and 4 (pressed level);
// the user must write them only while idle, as the core does not enforce it.
// ----------------------------------------------------------------------------
module button_debounce_long_press_core
  import bdlp_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 4,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  // Sample tick input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [NUM_BUTTONS-1:0]  raw_levels_i,
  input  logic [NUM_BUTTONS-1:0]  clear_press_i,
  input  logic [NUM_BUTTONS-1:0]  clear_long_i,

  // Result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [NUM_BUTTONS-1:0]  press_flags_o,
  output logic [NUM_BUTTONS-1:0]  long_flags_o,
  output logic [NUM_BUTTONS-1:0]  stable_levels_o,

  // Register port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [RegAddrWidth-1:0] paddr,
  input  logic [RegDataWidth-1:0] pwdata,
  output logic [RegDataWidth-1:0] prdata,
  output logic                    pready
);

  // Reset value of the hold counter, masked to the counter width.
  localparam logic [COUNT_WIDTH-1:0] HoldReset = LongTicksReset[COUNT_WIDTH-1:0];

  // Configuration registers
  logic [TicksRegWidth-1:0] long_ticks_q;
  logic                     pressed_level_q;
  logic                     reg_write;
  cfg_reg_e                 reg_sel;

  // Input register
  logic                     s1_valid_q;
  logic [NUM_BUTTONS-1:0]   raw_q;
  logic [NUM_BUTTONS-1:0]   clr_press_q;
  logic [NUM_BUTTONS-1:0]   clr_long_q;

  // Debounce state, which also serves as the result register
  logic                     out_valid_q;
  logic [NUM_BUTTONS-1:0]   oldest_q, oldest_d;
  logic [NUM_BUTTONS-1:0]   middle_q, middle_d;
  logic [NUM_BUTTONS-1:0]   newest_q, newest_d;
  logic [NUM_BUTTONS-1:0]   accepted_q, accepted_d;
  logic [NUM_BUTTONS-1:0]   press_q, press_d;
  logic [NUM_BUTTONS-1:0]   long_q, long_d;
  logic [COUNT_WIDTH-1:0]   hold_q, hold_d;

  // Handshake and datapath helpers
  logic                     in_take;
  logic                     out_take;
  logic                     res_free;
  logic                     advance;
  logic [31:0]              ticks_ext;
  logic [COUNT_WIDTH-1:0]   reload;
  logic [NUM_BUTTONS-1:0]   pressed_mask;

  // Register port: always ready, index taken from the word address.
  assign pready    = 1'b1;
  assign reg_sel   = cfg_reg_e'(paddr[2]);
  assign reg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q    <= LongTicksReset[TicksRegWidth-1:0];
      pressed_level_q <= 1'b0;
    end else if (reg_write) begin
      unique case (reg_sel)
        REG_LONG_TICKS:    long_ticks_q    <= pwdata[TicksRegWidth-1:0];
        REG_PRESSED_LEVEL: pressed_level_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_LONG_TICKS:    prdata = RegDataWidth'(long_ticks_q);
      REG_PRESSED_LEVEL: prdata = RegDataWidth'(pressed_level_q);
      default:           prdata = '0;
    endcase
  end

  // Flow control: the result register frees up when its transaction leaves.
  assign out_take   = out_valid_q & ~out_stall_i;
  assign res_free   = ~out_valid_q | ~out_stall_i;
  assign advance    = s1_valid_q & res_free;
  assign in_stall_o = s1_valid_q & ~res_free;
  assign in_take    = in_valid_i & ~in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      raw_q       <= raw_levels_i;
      clr_press_q <= clear_press_i;
      clr_long_q  <= clear_long_i;
    end
  end

  // Reload value, zero-extended or truncated to the counter width.
  assign ticks_ext = 32'(long_ticks_q);
  assign reload    = ticks_ext[COUNT_WIDTH-1:0];

  // Buttons whose accepted level is the pressed level.
  assign pressed_mask = pressed_level_q ? accepted_q : ~accepted_q;

  // Debounce update. The shared counter is passed through the buttons in
  // index order, so a lower button's reload or decrement is seen by the next.
  always_comb begin
    logic a_bit;
    logic b_bit;
    logic c_bit;
    press_d    = press_q & ~clr_press_q;
    long_d     = long_q & ~clr_long_q;
    oldest_d   = middle_q;
    middle_d   = newest_q;
    newest_d   = raw_q;
    accepted_d = accepted_q;
    hold_d     = hold_q;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      a_bit = middle_q[i];
      b_bit = newest_q[i];
      c_bit = raw_q[i];
      if ((a_bit == b_bit) && (b_bit == c_bit)) begin
        if (accepted_q[i] != c_bit) begin
          accepted_d[i] = c_bit;
          if (c_bit == pressed_level_q) begin
            press_d[i] = 1'b1;
            hold_d     = reload;
          end
        end else if (c_bit == pressed_level_q) begin
          hold_d = hold_d - COUNT_WIDTH'(1);
          if (hold_d == '0) begin
            long_d[i] = 1'b1;
            hold_d    = reload;
          end
        end
      end
    end
  end

  // State and result register, updated once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      oldest_q    <= '1;
      middle_q    <= '1;
      newest_q    <= '1;
      accepted_q  <= '1;
      press_q     <= '0;
      long_q      <= '0;
      hold_q      <= HoldReset;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        oldest_q    <= oldest_d;
        middle_q    <= middle_d;
        newest_q    <= newest_d;
        accepted_q  <= accepted_d;
        press_q     <= press_d;
        long_q      <= long_d;
        hold_q      <= hold_d;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign press_flags_o   = press_q;
  assign long_flags_o    = long_q;
  assign stable_levels_o = accepted_q;

  // The input side only stalls with both stages full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled while a stage is free");

  // Every update produces a result transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("update without a result");

  // With a nonzero reload the counter never rests at zero after an update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (reload != '0)) |=> (hold_q != '0))
    else $error("hold counter left at zero");

  // A newly raised long-press flag belongs to a button held pressed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> ((long_q & ~$past(long_q) & ~pressed_mask) == '0))
    else $error("long press raised for a released button");

endmodule : button_debounce_long_press_core

/* verif/button_debounce_flag_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_flag_checker: prediction and comparison for the debouncer
// Watches the sample tick channel, the result channel and the register port
// of the debouncer core. Every accepted tick is run through a local model of
// the three-sample history, the shared hold counter and the sticky flags,
// and every accepted result is compared field by field with the oldest
// prediction. Register reads are checked against the local register copies.
// ----------------------------------------------------------------------------
module button_debounce_flag_checker
  import bdlp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,

  // Sample tick channel, as seen on the core's ports
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [3:0]              raw_levels_i,
  input  logic [3:0]              clear_press_i,
  input  logic [3:0]              clear_long_i,

  // Result channel
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [3:0]              press_flags_i,
  input  logic [3:0]              long_flags_i,
  input  logic [3:0]              stable_levels_i,

  // Register port
  input  logic                    psel_i,
  input  logic                    penable_i,
  input  logic                    pwrite_i,
  input  logic [RegAddrWidth-1:0] paddr_i,
  input  logic [RegDataWidth-1:0] pwdata_i,
  input  logic [RegDataWidth-1:0] prdata_i,
  input  logic                    pready_i,

  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  localparam int NumButtons = 4;

  typedef struct packed {
    logic [3:0] press_flags;
    logic [3:0] long_flags;
    logic [3:0] stable_levels;
  } flag_report_t;

  // Local copies of the registers
  logic [15:0]  hold_ticks;
  logic         press_level;

  // Local copy of the debouncer state
  logic [3:0]   oldest_q;
  logic [3:0]   middle_q;
  logic [3:0]   newest_q;
  logic [3:0]   accepted_q;
  logic [15:0]  hold_count_q;
  logic [3:0]   press_sticky_q;
  logic [3:0]   long_sticky_q;

  flag_report_t reports_due[$];
  int unsigned  mismatches = 0;

  // Advance the local state by one sample tick and return the flags and
  // accepted levels that the core should report for it.
  function automatic flag_report_t debounce_tick(input logic [3:0] raw,
                                                 input logic [3:0] clr_press,
                                                 input logic [3:0] clr_long);
    flag_report_t report;
    logic [15:0]  reload;
    logic         held;
    int           i;
    reload = hold_ticks;
    press_sticky_q = press_sticky_q & ~clr_press;
    long_sticky_q  = long_sticky_q & ~clr_long;
    oldest_q = middle_q;
    middle_q = newest_q;
    newest_q = raw;
    // Buttons share one hold counter and are taken in index order.
    for (i = 0; i < NumButtons; i++) begin
      held = (newest_q[i] == press_level);
      if (oldest_q[i] == middle_q[i] && middle_q[i] == newest_q[i]) begin
        if (accepted_q[i] != newest_q[i]) begin
          accepted_q[i] = newest_q[i];
          if (held) begin
            press_sticky_q[i] = 1'b1;
            hold_count_q      = reload;
          end
        end else if (held) begin
          hold_count_q = hold_count_q - 16'd1;
          if (hold_count_q == 16'd0) begin
            long_sticky_q[i] = 1'b1;
            hold_count_q     = reload;
          end
        end
      end
    end
    report.press_flags   = press_sticky_q;
    report.long_flags    = long_sticky_q;
    report.stable_levels = accepted_q;
    return report;
  endfunction

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatches++;
    end
  endfunction

  // Track the register port and both channels at every clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    flag_report_t       due;
    logic [31:0]        reg_value;
    if (!rst_ni) begin
      hold_ticks     = LongTicksReset[15:0];
      press_level    = 1'b0;
      oldest_q       = 4'hF;
      middle_q       = 4'hF;
      newest_q       = 4'hF;
      accepted_q     = 4'hF;
      hold_count_q   = LongTicksReset[15:0];
      press_sticky_q = 4'h0;
      long_sticky_q  = 4'h0;
      reports_due.delete();
    end else begin
      // Register accesses complete in the access phase.
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (cfg_reg_e'(paddr_i[RegAddrWidth-1:2]))
            REG_LONG_TICKS:    hold_ticks  = pwdata_i[15:0];
            REG_PRESSED_LEVEL: press_level = pwdata_i[0];
            default: ;
          endcase
        end else begin
          case (cfg_reg_e'(paddr_i[RegAddrWidth-1:2]))
            REG_LONG_TICKS:    reg_value = {16'd0, hold_ticks};
            default:           reg_value = {31'd0, press_level};
          endcase
          if (prdata_i !== reg_value) begin
            $error("prdata: expected %h, actual %h", reg_value, prdata_i);
            mismatches++;
          end
        end
      end

      // Results are matched before this edge's tick is predicted.
      if (out_valid_i && !out_stall_i) begin
        if (reports_due.size() == 0) begin
          $error("result transaction with no prediction waiting: %h %h %h",
                 press_flags_i, long_flags_i, stable_levels_i);
          mismatches++;
        end else begin
          due = reports_due.pop_front();
          check_field("press_flags", due.press_flags, press_flags_i);
          check_field("long_flags", due.long_flags, long_flags_i);
          check_field("stable_levels", due.stable_levels, stable_levels_i);
        end
      end

      if (in_valid_i && !in_stall_i) begin
        reports_due.push_back(debounce_tick(raw_levels_i, clear_press_i, clear_long_i));
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= reports_due.size();
  end

endmodule : button_debounce_flag_checker

/* verif/button_debounce_long_press_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_core_test: regression of the debouncer core
// Drives sample ticks and acknowledge masks into the core under a range of
// register settings and back-pressure patterns: a directed opening, a level
// flip, a zero-reload hold, then phases of random press, hold and glitch
// sequences. The checker beside the core predicts and compares the results.
// ----------------------------------------------------------------------------
module button_debounce_long_press_core_test;
  import bdlp_pkg::*;

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;

  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic [3:0]              raw_levels  = 4'hF;
  logic [3:0]              clear_press = 4'h0;
  logic [3:0]              clear_long  = 4'h0;

  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic [3:0]              press_flags;
  logic [3:0]              long_flags;
  logic [3:0]              stable_levels;

  logic                    psel        = 1'b0;
  logic                    penable     = 1'b0;
  logic                    pwrite      = 1'b0;
  logic [RegAddrWidth-1:0] paddr       = '0;
  logic [RegDataWidth-1:0] pwdata      = '0;
  logic [RegDataWidth-1:0] prdata;
  logic                    pready;

  int unsigned             failures;
  int unsigned             pending;

  int unsigned             in_idle_pct   = 0;
  int unsigned             out_stall_pct = 0;

  // Settings of the random phases.
  localparam logic [15:0] PhaseTicks [8] = '{16'd300, 16'd1, 16'd65535, 16'd5,
                                             16'd17, 16'd2, 16'd40, 16'd9};
  localparam logic        PhaseLevel [8] = '{1'b0, 1'b1, 1'b0, 1'b1,
                                             1'b0, 1'b1, 1'b1, 1'b0};
  localparam int unsigned InIdle [4]     = '{0, 49, 0, 34};
  localparam int unsigned OutStall [4]   = '{0, 0, 49, 34};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  button_debounce_long_press_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .raw_levels_i    (raw_levels),
    .clear_press_i   (clear_press),
    .clear_long_i    (clear_long),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .press_flags_o   (press_flags),
    .long_flags_o    (long_flags),
    .stable_levels_o (stable_levels),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  button_debounce_flag_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .raw_levels_i    (raw_levels),
    .clear_press_i   (clear_press),
    .clear_long_i    (clear_long),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .press_flags_i   (press_flags),
    .long_flags_i    (long_flags),
    .stable_levels_i (stable_levels),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .pready_i        (pready),
    .fail_count_o    (failures),
    .pending_o       (pending)
  );

  // The result side stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // One register transaction: setup cycle, then access until pready.
  task automatic register_access(input logic write, input cfg_reg_e index,
                                 input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write both registers, with noise in the unused upper bits, and read back.
  task automatic set_config(input logic [15:0] ticks, input logic level);
    register_access(1'b1, REG_LONG_TICKS, {16'($urandom), ticks});
    register_access(1'b1, REG_PRESSED_LEVEL, {31'($urandom), level});
    register_access(1'b0, REG_LONG_TICKS, '0);
    register_access(1'b0, REG_PRESSED_LEVEL, '0);
  endtask

  // Offer one sample tick, after a random idle gap, and wait for acceptance.
  task automatic send_tick(input logic [3:0] raw, input logic [3:0] clr_press,
                           input logic [3:0] clr_long);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid    <= 1'b0;
      raw_levels  <= 4'($urandom);
      clear_press <= 4'($urandom);
      clear_long  <= 4'($urandom);
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    raw_levels  <= raw;
    clear_press <= clr_press;
    clear_long  <= clr_long;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering ticks and wait until every predicted result has arrived.
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Random press, hold and release sequences with occasional glitches and
  // acknowledge masks. Long holds let the shared counter run out.
  task automatic run_random(input int count);
    logic [3:0] level;
    logic [3:0] raw;
    logic [3:0] clr_press;
    logic [3:0] clr_long;
    int         run;
    run   = 0;
    level = 4'hF;
    repeat (count) begin
      if (run == 0) begin
        level = 4'($urandom);
        run   = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
      end
      raw       = ($urandom_range(7) == 0) ? 4'($urandom) : level;
      clr_press = ($urandom_range(3) == 0) ? 4'($urandom) : 4'h0;
      clr_long  = ($urandom_range(3) == 0) ? 4'($urandom) : 4'h0;
      send_tick(raw, clr_press, clr_long);
      run--;
    end
  endtask

  initial begin
    int phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers must read back their reset values.
    register_access(1'b0, REG_LONG_TICKS, '0);
    register_access(1'b0, REG_PRESSED_LEVEL, '0);

    // All buttons pressed together with a short reload: the shared counter
    // fires for alternate buttons within one tick.
    set_config(16'd2, 1'b0);
    send_tick(4'hF, 4'h0, 4'h0);
    repeat (5) send_tick(4'h0, 4'h0, 4'h0);
    // Long-press flags of buttons 1 and 3, cleared and set again in the same tick, stay set.
    send_tick(4'h0, 4'hF, 4'hF);
    // Alternating glitches never become stable.
    send_tick(4'h5, 4'hA, 4'h5);
    send_tick(4'hA, 4'h0, 4'h0);
    send_tick(4'h5, 4'h0, 4'h0);
    repeat (3) send_tick(4'hF, 4'hF, 4'hF);
    repeat (5) send_tick(4'hE, 4'h0, 4'h0);
    drain;

    // Pressed level flips while the history is kept.
    set_config(16'd2, 1'b1);
    repeat (4) send_tick(4'hF, 4'h0, 4'h0);
    drain;

    // Zero reload: the counter wraps, so a short hold raises no long press.
    set_config(16'd0, 1'b1);
    repeat (3) send_tick(4'h0, 4'h0, 4'h0);
    repeat (40) send_tick(4'h1, 4'h0, 4'h0);
    drain;

    // Random phases across register settings and back-pressure patterns.
    for (phase = 0; phase < 8; phase++) begin
      set_config(PhaseTicks[phase], PhaseLevel[phase]);
      in_idle_pct   = InIdle[phase % 4];
      out_stall_pct = OutStall[phase % 4];
      run_random(85);
      drain;
    end

    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("button_debounce_long_press_core regression: pass");
    end else begin
      $display("button_debounce_long_press_core regression: fail");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("button_debounce_long_press_core regression: fail");
    $finish;
  end

endmodule : button_debounce_long_press_core_test

/* filelist.f */
rtl/bdlp_pkg.sv
rtl/button_debounce_long_press_core.sv
verif/button_debounce_flag_checker.sv
verif/button_debounce_long_press_core_test.sv
